@@ hw/rtl/ddodo_pkg.sv @@
// Shared types, widths and constants of the differential-drive odometry block.
// Holds the arctangent table used by the rotation unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ddodo_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DEF_CORDIC_STEPS = 16;
   localparam int TAB_LEN = 24;
   localparam int TAB_IDX_W = $clog2(TAB_LEN);

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam int DELTA_W = 20;
   localparam int SUMDIFF_W = DELTA_W + 1;
   localparam int POS_W = 40;
   localparam int HEAD_W = 20;
   localparam int HEAD_OUT_W = 19;
   localparam int HIBR_W = 24;
   localparam int TRIG_FRAC = 30;
   localparam int TRIG_W = 34;
   localparam int Z_W = 36;
   localparam int PROD_W = TRIG_W + SUMDIFF_W;
   localparam int HEAD_SHIFT = TRIG_FRAC - FRAC_BITS;
   localparam int POS_SHIFT = TRIG_FRAC + 1;

   localparam logic [HIBR_W-1:0] HIBR_RESET = HIBR_W'(131072);

   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam longint PI_Q = (PI_Q30 + (64'sd1 << (HEAD_SHIFT - 1))) >>> HEAD_SHIFT;

   typedef logic signed [Z_W-1:0] angle_type;
   typedef logic signed [TRIG_W-1:0] trig_type;

   typedef struct packed {
      logic load;
      logic step;
   } cordic_ctrl_type;

   function automatic angle_type atan_entry(input logic [TAB_IDX_W-1:0] idx);
      angle_type r;
      unique case (idx)
         5'd0:  r = angle_type'(843314857);
         5'd1:  r = angle_type'(497837829);
         5'd2:  r = angle_type'(263043837);
         5'd3:  r = angle_type'(133525159);
         5'd4:  r = angle_type'(67021687);
         5'd5:  r = angle_type'(33543516);
         5'd6:  r = angle_type'(16775851);
         5'd7:  r = angle_type'(8388437);
         5'd8:  r = angle_type'(4194283);
         5'd9:  r = angle_type'(2097149);
         5'd10: r = angle_type'(1048576);
         5'd11: r = angle_type'(524288);
         5'd12: r = angle_type'(262144);
         5'd13: r = angle_type'(131072);
         5'd14: r = angle_type'(65536);
         5'd15: r = angle_type'(32768);
         5'd16: r = angle_type'(16384);
         5'd17: r = angle_type'(8192);
         5'd18: r = angle_type'(4096);
         5'd19: r = angle_type'(2048);
         5'd20: r = angle_type'(1024);
         5'd21: r = angle_type'(512);
         5'd22: r = angle_type'(256);
         5'd23: r = angle_type'(128);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ddodo_cordic.sv @@
// Iterative CORDIC rotation unit: one micro-rotation per step, giving
// the cosine and sine of the heading in Q30. Depends on ddodo_pkg.
`default_nettype none

module ddodo_cordic #(
   parameter int STEPS = ddodo_pkg::DEF_CORDIC_STEPS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ddodo_pkg::cordic_ctrl_type              ctrl,
   input  logic signed [ddodo_pkg::HEAD_W-1:0]     angle_in,
   output ddodo_pkg::trig_type                     cos_out,
   output ddodo_pkg::trig_type                     sin_out,
   output logic                                    last_out
);
   import ddodo_pkg::*;

   localparam int STEPS_EFF = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;
   localparam int ITER_W = (STEPS_EFF > 1) ? $clog2(STEPS_EFF) : 1;
   localparam angle_type HALF_PI_Z = angle_type'(HALF_PI_Q30);
   localparam angle_type PI_Z = angle_type'(PI_Q30);

   logic [ITER_W-1:0] iter_ff, iter_in;
   trig_type x_ff, x_in, y_ff, y_in;
   angle_type z_ff, z_in;
   logic flip_ff, flip_in;

   angle_type z0, at;
   trig_type dx, dy;

   assign z0 = angle_type'(angle_in) <<< HEAD_SHIFT;
   assign dx = y_ff >>> iter_ff;
   assign dy = x_ff >>> iter_ff;
   assign at = atan_entry(TAB_IDX_W'(iter_ff));

   always_comb begin
      iter_in = iter_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      flip_in = flip_ff;
      if (ctrl.load) begin
         iter_in = '0;
         x_in = trig_type'(GAIN_Q30);
         y_in = '0;
         if (z0 > HALF_PI_Z) begin
            z_in = z0 - PI_Z;
            flip_in = 1'b1;
         end else if (z0 < -HALF_PI_Z) begin
            z_in = z0 + PI_Z;
            flip_in = 1'b1;
         end else begin
            z_in = z0;
            flip_in = 1'b0;
         end
      end else if (ctrl.step) begin
         iter_in = iter_ff + 1'b1;
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
   end

   assign last_out = (iter_ff == ITER_W'(STEPS_EFF - 1));
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ddodo_mul.sv @@
// Shared signed multiplier with a registered product, used for the turn
// scaling and both position increments. Depends on ddodo_pkg.
`default_nettype none

module ddodo_mul (
   input  logic                                    clock,
   input  ddodo_pkg::trig_type                     a_in,
   input  logic signed [ddodo_pkg::SUMDIFF_W-1:0]  b_in,
   output logic signed [ddodo_pkg::PROD_W-1:0]     prod_out
);
   import ddodo_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = PROD_W'(a_in * b_in);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod_out = prod_ff;

endmodule

`default_nettype wire

@@ hw/rtl/diff_drive_odometry_core.sv @@
// Top level of the differential-drive odometry block: sequencer, pose state,
// output register and configuration register. Depends on ddodo_pkg,
// ddodo_cordic and ddodo_mul.
//
// Usage: each req beat is either a pose load or an update with left and right
// wheel increments. Every beat gives exactly one rsp beat carrying the pose,
// the accumulated forward travel and a saturation flag.
// An update beat runs CORDIC_STEPS rotation steps (at most 24) of the CORDIC unit,
// then two products on the shared multiplier and the accumulation; its rsp
// beat is then loaded into the output register and req_ready rises again as it is
// loaded, so a new req beat is taken only once the last one is done. A load beat
// skips rotation and products. Most of an update's time goes to the rotation loop.
// req_ready is high only while the sequencer is idle; a finished rsp beat waits
// in the output register, so a new req beat is taken while it is stalled.
// If the receiver still holds off when the next result is done, the sequencer
// waits and accepts nothing until the output register frees.
// Synchronous reset clears the pose and travel to zero, restores the turn
// scale register to 0.5 / 0.25 m and leaves no rsp beat pending.
// csr_wr_en writes the turn scale at once; write it only while idle.
`default_nettype none

module diff_drive_odometry_core #(
   parameter int CORDIC_STEPS = ddodo_pkg::DEF_CORDIC_STEPS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_command,
   input  logic signed [ddodo_pkg::DELTA_W-1:0]     req_left_delta,
   input  logic signed [ddodo_pkg::DELTA_W-1:0]     req_right_delta,
   input  logic signed [ddodo_pkg::POS_W-1:0]       req_load_x,
   input  logic signed [ddodo_pkg::POS_W-1:0]       req_load_y,
   input  logic signed [ddodo_pkg::HEAD_OUT_W-1:0]  req_load_heading,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [ddodo_pkg::POS_W-1:0]       rsp_pos_x_out,
   output logic signed [ddodo_pkg::POS_W-1:0]       rsp_pos_y_out,
   output logic signed [ddodo_pkg::HEAD_OUT_W-1:0]  rsp_heading_out,
   output logic signed [ddodo_pkg::POS_W-1:0]       rsp_forward_travel_out,
   output logic                                     rsp_saturated,
   input  logic                                     csr_wr_en,
   input  logic [ddodo_pkg::HIBR_W-1:0]             csr_wr_data
);
   import ddodo_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ROT  = 3'd1;
   localparam logic [2:0] ST_MULC = 3'd2;
   localparam logic [2:0] ST_MULS = 3'd3;
   localparam logic [2:0] ST_ACC  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam logic signed [HEAD_W:0] HEAD_PI = (HEAD_W + 1)'(PI_Q);
   localparam logic signed [HEAD_W:0] HEAD_TWO_PI = (HEAD_W + 1)'(2 * PI_Q);
   localparam logic signed [HEAD_W-1:0] DTH_PI = HEAD_W'(PI_Q);
   localparam logic signed [PROD_W:0] PROD_PI = (PROD_W + 1)'(PI_Q);
   localparam logic signed [PROD_W:0] RND_TURN = (PROD_W + 1)'(64'sd1 << (FRAC_BITS - 1));
   localparam logic signed [PROD_W:0] RND_POS = (PROD_W + 1)'(64'sd1 << (POS_SHIFT - 1));

   function automatic logic signed [HEAD_W-1:0] wrap_angle(input logic signed [HEAD_W:0] a);
      logic signed [HEAD_W:0] r;
      r = a;
      if (a >= HEAD_PI) begin
         r = a - HEAD_TWO_PI;
      end else if (a < -HEAD_PI) begin
         r = a + HEAD_TWO_PI;
      end
      return r[HEAD_W-1:0];
   endfunction

   // Returns the saturation flag above the clipped sum.
   function automatic logic [POS_W:0] sat_add(input logic signed [POS_W-1:0] a,
                                              input logic signed [POS_W:0] b);
      logic signed [POS_W:0] s;
      logic [POS_W:0] r;
      s = (POS_W + 1)'(a) + b;
      if (s[POS_W] != s[POS_W-1]) begin
         r = {1'b1, s[POS_W], {(POS_W - 1){~s[POS_W]}}};
      end else begin
         r = {1'b0, s[POS_W-1:0]};
      end
      return r;
   endfunction

   logic [2:0] state_ff, state_in;
   logic [HIBR_W-1:0] hibr_ff, hibr_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [POS_W-1:0] travel_ff, travel_in;
   logic signed [HEAD_W-1:0] heading_ff, heading_in;
   logic signed [HEAD_W-1:0] dth_ff, dth_in;
   logic signed [SUMDIFF_W-1:0] sum_ff, sum_in, diff_ff, diff_in;
   logic sat_ff, sat_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in, out_tr_ff, out_tr_in;
   logic signed [HEAD_OUT_W-1:0] out_hd_ff, out_hd_in;
   logic out_sat_ff, out_sat_in;

   logic accept;
   cordic_ctrl_type cordic_ctrl;
   trig_type cos_val, sin_val, mul_a;
   logic cordic_last;
   logic signed [SUMDIFF_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W:0] turn_full, pos_full;
   logic signed [POS_W:0] pos_inc;
   logic signed [SUMDIFF_W:0] travel_full;
   logic [POS_W:0] sum_x, sum_y, sum_tr;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;

   assign cordic_ctrl.load = accept && (req_command == CMD_UPDATE);
   assign cordic_ctrl.step = (state_ff == ST_ROT);

   ddodo_cordic #(
      .STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .ctrl(cordic_ctrl),
      .angle_in(heading_ff),
      .cos_out(cos_val),
      .sin_out(sin_val),
      .last_out(cordic_last)
   );

   always_comb begin
      unique case (state_ff)
         ST_MULC: begin
            mul_a = cos_val;
            mul_b = diff_ff;
         end
         ST_MULS: begin
            mul_a = sin_val;
            mul_b = diff_ff;
         end
         default: begin
            mul_a = trig_type'(hibr_ff);
            mul_b = sum_ff;
         end
      endcase
   end

   ddodo_mul u_mul (
      .clock(clock),
      .a_in(mul_a),
      .b_in(mul_b),
      .prod_out(prod)
   );

   assign turn_full = ((PROD_W + 1)'(prod) + RND_TURN) >>> FRAC_BITS;
   assign pos_full = ((PROD_W + 1)'(prod) + RND_POS) >>> POS_SHIFT;
   assign pos_inc = (POS_W + 1)'(pos_full);
   assign travel_full = ((SUMDIFF_W + 1)'(diff_ff) + (SUMDIFF_W + 1)'(1)) >>> 1;
   assign sum_x = sat_add(pos_x_ff, pos_inc);
   assign sum_y = sat_add(pos_y_ff, pos_inc);
   assign sum_tr = sat_add(travel_ff, (POS_W + 1)'(travel_full));

   always_comb begin
      state_in = state_ff;
      hibr_in = csr_wr_en ? csr_wr_data : hibr_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      travel_in = travel_ff;
      heading_in = heading_ff;
      dth_in = dth_ff;
      sum_in = sum_ff;
      diff_in = diff_ff;
      sat_in = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_tr_in = out_tr_ff;
      out_hd_in = out_hd_ff;
      out_sat_in = out_sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sum_in = SUMDIFF_W'(req_left_delta) + SUMDIFF_W'(req_right_delta);
               diff_in = SUMDIFF_W'(req_right_delta) - SUMDIFF_W'(req_left_delta);
               sat_in = 1'b0;
               if (req_command == CMD_LOAD) begin
                  pos_x_in = req_load_x;
                  pos_y_in = req_load_y;
                  heading_in = wrap_angle((HEAD_W + 1)'(req_load_heading));
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ROT;
               end
            end
         end
         ST_ROT: begin
            if (turn_full > PROD_PI) begin
               dth_in = DTH_PI;
            end else if (turn_full < -PROD_PI) begin
               dth_in = -DTH_PI;
            end else begin
               dth_in = turn_full[HEAD_W-1:0];
            end
            if (cordic_last) begin
               state_in = ST_MULC;
            end
         end
         ST_MULC: begin
            state_in = ST_MULS;
         end
         ST_MULS: begin
            pos_x_in = sum_x[POS_W-1:0];
            sat_in = sat_ff | sum_x[POS_W];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            pos_y_in = sum_y[POS_W-1:0];
            travel_in = sum_tr[POS_W-1:0];
            sat_in = sat_ff | sum_y[POS_W] | sum_tr[POS_W];
            heading_in = wrap_angle((HEAD_W + 1)'(heading_ff) + (HEAD_W + 1)'(dth_ff));
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_x_in = pos_x_ff;
               out_y_in = pos_y_ff;
               out_tr_in = travel_ff;
               out_hd_in = heading_ff[HEAD_OUT_W-1:0];
               out_sat_in = sat_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hibr_ff <= HIBR_RESET;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         travel_ff <= '0;
         heading_ff <= '0;
         sat_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hibr_ff <= hibr_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         travel_ff <= travel_in;
         heading_ff <= heading_in;
         sat_ff <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dth_ff <= dth_in;
      sum_ff <= sum_in;
      diff_ff <= diff_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_tr_ff <= out_tr_in;
      out_hd_ff <= out_hd_in;
      out_sat_ff <= out_sat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x_out = out_x_ff;
   assign rsp_pos_y_out = out_y_ff;
   assign rsp_heading_out = out_hd_ff;
   assign rsp_forward_travel_out = out_tr_ff;
   assign rsp_saturated = out_sat_ff;

`ifndef ASSERT_OFF
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      ((HEAD_W + 1)'(heading_ff) >= -HEAD_PI) && ((HEAD_W + 1)'(heading_ff) < HEAD_PI))
      else $error("heading left the wrapped range");

   a_turn_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULC) |-> ((dth_ff <= DTH_PI) && (dth_ff >= -DTH_PI)))
      else $error("turn increment beyond pi");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready |=> (state_ff == ST_DONE))
      else $error("result finished over a stalled beat");

   a_load_clears_sat: assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == CMD_LOAD) |=> !sat_ff && (state_ff == ST_DONE))
      else $error("load beat did not clear saturation");
`endif

endmodule

`default_nettype wire

@@ tb/sv/diff_drive_odometry_check.sv @@
// Checker for the differential-drive odometry core: watches the req, rsp and csr ports,
// predicts the pose after every accepted req beat and compares each rsp beat in order.
// Depends on ddodo_pkg for port widths and command codes.
`timescale 1ns / 100ps

module diff_drive_odometry_check (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic                                     req_command,
   input  logic signed [ddodo_pkg::DELTA_W-1:0]     req_left_delta,
   input  logic signed [ddodo_pkg::DELTA_W-1:0]     req_right_delta,
   input  logic signed [ddodo_pkg::POS_W-1:0]       req_load_x,
   input  logic signed [ddodo_pkg::POS_W-1:0]       req_load_y,
   input  logic signed [ddodo_pkg::HEAD_OUT_W-1:0]  req_load_heading,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic signed [ddodo_pkg::POS_W-1:0]       rsp_pos_x_out,
   input  logic signed [ddodo_pkg::POS_W-1:0]       rsp_pos_y_out,
   input  logic signed [ddodo_pkg::HEAD_OUT_W-1:0]  rsp_heading_out,
   input  logic signed [ddodo_pkg::POS_W-1:0]       rsp_forward_travel_out,
   input  logic                                     rsp_saturated,
   input  logic                                     csr_wr_en,
   input  logic [ddodo_pkg::HIBR_W-1:0]             csr_wr_data,
   output int                                       fail_count,
   output int                                       pending_count
);

   typedef logic signed [ddodo_pkg::DELTA_W-1:0] wheel_step;
   typedef logic signed [ddodo_pkg::POS_W-1:0] position_word;
   typedef logic signed [ddodo_pkg::HEAD_OUT_W-1:0] heading_word;
   typedef logic [ddodo_pkg::HIBR_W-1:0] turn_scale_word;

   typedef struct {
      logic         command;
      wheel_step    left_delta;
      wheel_step    right_delta;
      position_word load_x;
      position_word load_y;
      heading_word  load_heading;
   } odo_beat;

   typedef struct {
      position_word pos_x;
      position_word pos_y;
      heading_word  heading;
      position_word travel;
      logic         saturated;
   } pose_report;

   localparam int FRAC = ddodo_pkg::FRAC_BITS;
   localparam int ROT_STEPS = ddodo_pkg::DEF_CORDIC_STEPS;
   localparam longint PI_FX = 64'sd205887;
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint CORDIC_GAIN = 64'sd652032874;
   localparam longint Z_SCALE = 64'sd1 <<< (30 - FRAC);
   localparam longint RAIL_HIGH = 64'sd549755813887;
   localparam longint RAIL_LOW = -64'sd549755813888;

   longint atan_q30 [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128
   };

   turn_scale_word turn_scale;
   longint est_x;
   longint est_y;
   longint est_heading;
   longint est_travel;
   pose_report pending_poses [$];
   int mismatches = 0;
   int due = 0;

   assign fail_count = mismatches;
   assign pending_count = due;

   function automatic longint round_shift(input longint v, input int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint wrap_heading(input longint a);
      longint m;
      m = (a + PI_FX) % (2 * PI_FX);
      if (m < 0) begin
         m += 2 * PI_FX;
      end
      return m - PI_FX;
   endfunction

   function automatic longint clip_add(input longint a, input longint b, inout bit clipped);
      longint s;
      s = a + b;
      if (s > RAIL_HIGH) begin
         clipped = 1'b1;
         return RAIL_HIGH;
      end
      if (s < RAIL_LOW) begin
         clipped = 1'b1;
         return RAIL_LOW;
      end
      return s;
   endfunction

   // Cosine and sine of the heading, both Q30, folded into the right half plane first.
   function automatic void heading_trig(input longint ang, output longint cos_q,
                                        output longint sin_q);
      longint z;
      longint x;
      longint y;
      longint dx;
      longint dy;
      bit flip;
      z = ang * Z_SCALE;
      x = CORDIC_GAIN;
      y = 0;
      flip = 1'b0;
      if (z > HALF_PI_Q30) begin
         z -= PI_Q30;
         flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z += PI_Q30;
         flip = 1'b1;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= atan_q30[i];
         end else begin
            x += dx;
            y -= dy;
            z += atan_q30[i];
         end
      end
      cos_q = flip ? -x : x;
      sin_q = flip ? -y : y;
   endfunction

   function automatic pose_report advance_pose(input odo_beat b);
      pose_report r;
      longint lft;
      longint rgt;
      longint diff;
      longint turn;
      longint cos_q;
      longint sin_q;
      bit clipped;
      clipped = 1'b0;
      if (b.command == ddodo_pkg::CMD_LOAD) begin
         est_x = longint'(b.load_x);
         est_y = longint'(b.load_y);
         est_heading = wrap_heading(longint'(b.load_heading));
      end else begin
         lft = longint'(b.left_delta);
         rgt = longint'(b.right_delta);
         diff = rgt - lft;
         turn = round_shift(longint'(turn_scale) * (lft + rgt), FRAC);
         if (turn > PI_FX) begin
            turn = PI_FX;
         end
         if (turn < -PI_FX) begin
            turn = -PI_FX;
         end
         heading_trig(est_heading, cos_q, sin_q);
         est_x = clip_add(est_x, round_shift(diff * cos_q, 31), clipped);
         est_y = clip_add(est_y, round_shift(diff * sin_q, 31), clipped);
         est_travel = clip_add(est_travel, round_shift(diff, 1), clipped);
         est_heading = wrap_heading(est_heading + turn);
      end
      r.pos_x = position_word'(est_x);
      r.pos_y = position_word'(est_y);
      r.heading = heading_word'(est_heading);
      r.travel = position_word'(est_travel);
      r.saturated = clipped;
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      odo_beat beat;
      pose_report want;
      if (reset) begin
         turn_scale = 24'd131072;
         est_x = 0;
         est_y = 0;
         est_heading = 0;
         est_travel = 0;
         pending_poses.delete();
      end else begin
         if (csr_wr_en) begin
            turn_scale = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_poses.size() == 0) begin
               mismatches++;
               $error("rsp beat arrived with no pose expected");
            end else begin
               want = pending_poses.pop_front();
               check_field("pos_x_out", want.pos_x, rsp_pos_x_out);
               check_field("pos_y_out", want.pos_y, rsp_pos_y_out);
               check_field("heading_out", want.heading, rsp_heading_out);
               check_field("forward_travel_out", want.travel, rsp_forward_travel_out);
               check_field("saturated", want.saturated, rsp_saturated);
            end
         end
         if (req_valid && req_ready) begin
            beat.command = req_command;
            beat.left_delta = req_left_delta;
            beat.right_delta = req_right_delta;
            beat.load_x = req_load_x;
            beat.load_y = req_load_y;
            beat.load_heading = req_load_heading;
            pending_poses.push_back(advance_pose(beat));
         end
      end
      due <= pending_poses.size();
   end

endmodule

@@ tb/sv/diff_drive_odometry_core_test.sv @@
// Testbench top for the differential-drive odometry core: drives directed and random
// req beats and turn scale writes, stalls both channels at random and reports the verdict.
// Depends on ddodo_pkg, diff_drive_odometry_core and diff_drive_odometry_check.
`timescale 1ns / 100ps

module diff_drive_odometry_core_test;

   typedef logic signed [ddodo_pkg::DELTA_W-1:0] wheel_step;
   typedef logic signed [ddodo_pkg::POS_W-1:0] position_word;
   typedef logic signed [ddodo_pkg::HEAD_OUT_W-1:0] heading_word;
   typedef logic [ddodo_pkg::HIBR_W-1:0] turn_scale_word;

   localparam position_word POS_TOP = {1'b0, {(ddodo_pkg::POS_W - 1){1'b1}}};
   localparam position_word POS_BOTTOM = {1'b1, {(ddodo_pkg::POS_W - 1){1'b0}}};
   localparam int PI_FX = 205887;
   localparam int HALF_PI_FX = 102944;
   localparam wheel_step STEP_MAX = {1'b0, {(ddodo_pkg::DELTA_W - 1){1'b1}}};
   localparam wheel_step STEP_MIN = {1'b1, {(ddodo_pkg::DELTA_W - 1){1'b0}}};

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_command;
   wheel_step req_left_delta;
   wheel_step req_right_delta;
   position_word req_load_x;
   position_word req_load_y;
   heading_word req_load_heading;
   logic rsp_valid;
   logic rsp_ready;
   position_word rsp_pos_x_out;
   position_word rsp_pos_y_out;
   heading_word rsp_heading_out;
   position_word rsp_forward_travel_out;
   logic rsp_saturated;
   logic csr_wr_en;
   turn_scale_word csr_wr_data;
   int fail_count;
   int pending_count;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;
   bit receiver_hold = 1'b0;

   always #1 clock = ~clock;

   diff_drive_odometry_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_left_delta         (req_left_delta),
      .req_right_delta        (req_right_delta),
      .req_load_x             (req_load_x),
      .req_load_y             (req_load_y),
      .req_load_heading       (req_load_heading),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_pos_x_out          (rsp_pos_x_out),
      .rsp_pos_y_out          (rsp_pos_y_out),
      .rsp_heading_out        (rsp_heading_out),
      .rsp_forward_travel_out (rsp_forward_travel_out),
      .rsp_saturated          (rsp_saturated),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data)
   );

   diff_drive_odometry_check pose_check (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_left_delta         (req_left_delta),
      .req_right_delta        (req_right_delta),
      .req_load_x             (req_load_x),
      .req_load_y             (req_load_y),
      .req_load_heading       (req_load_heading),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_pos_x_out          (rsp_pos_x_out),
      .rsp_pos_y_out          (rsp_pos_y_out),
      .rsp_heading_out        (rsp_heading_out),
      .rsp_forward_travel_out (rsp_forward_travel_out),
      .rsp_saturated          (rsp_saturated),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .fail_count             (fail_count),
      .pending_count          (pending_count)
   );

   function automatic position_word rand_position();
      return position_word'({$urandom(), $urandom()});
   endfunction

   function automatic position_word near_rail();
      position_word off;
      off = position_word'($urandom_range(0, 1 << 20));
      return ($urandom_range(0, 1) != 0) ? POS_TOP - off : POS_BOTTOM + off;
   endfunction

   task automatic send_beat(input logic cmd, input wheel_step lft, input wheel_step rgt,
                            input position_word x, input position_word y,
                            input heading_word h);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) begin
         sender_calm = !sender_calm;
      end
      gap = sender_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command <= cmd;
      req_left_delta <= lft;
      req_right_delta <= rgt;
      req_load_x <= x;
      req_load_y <= y;
      req_load_heading <= h;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_update(input wheel_step lft, input wheel_step rgt);
      send_beat(ddodo_pkg::CMD_UPDATE, lft, rgt, rand_position(), rand_position(),
                heading_word'($urandom()));
   endtask

   task automatic send_load(input position_word x, input position_word y, input int h);
      send_beat(ddodo_pkg::CMD_LOAD, wheel_step'($urandom()), wheel_step'($urandom()),
                x, y, heading_word'(h));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_turn_scale(input turn_scale_word value);
      drain();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Writes the turn scale, then a random mix of small, medium and full-range wheel steps and pose loads.
   task automatic run_phase(input turn_scale_word scale, input int beats, input bit hold);
      int choice;
      int fwd;
      int twist;
      write_turn_scale(scale);
      for (int i = 0; i < beats; i++) begin
         if (hold && i == beats / 2) begin
            receiver_hold = 1'b1;
         end
         choice = $urandom_range(0, 99);
         if (choice < 6) begin
            send_beat(ddodo_pkg::CMD_LOAD, wheel_step'($urandom()), wheel_step'($urandom()),
                      rand_position(), rand_position(), heading_word'($urandom()));
         end else if (choice < 11) begin
            send_load(near_rail(), near_rail(), int'($urandom_range(0, 2 * PI_FX)) - PI_FX);
         end else if (choice < 60) begin
            fwd = int'($urandom_range(0, 7000)) - 1000;
            twist = int'($urandom_range(0, 800)) - 400;
            send_update(wheel_step'(twist - fwd), wheel_step'(twist + fwd));
         end else if (choice < 85) begin
            send_update(wheel_step'(int'($urandom_range(0, 262144)) - 131072),
                        wheel_step'(int'($urandom_range(0, 262144)) - 131072));
         end else begin
            send_update(wheel_step'($urandom()), wheel_step'($urandom()));
         end
      end
   endtask

   initial begin : result_sink
      int unsigned gap;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (receiver_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            receiver_hold = 1'b0;
         end
         if ($urandom_range(0, 39) == 0) begin
            receiver_calm = !receiver_calm;
         end
         gap = receiver_calm ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = ddodo_pkg::CMD_UPDATE;
      req_left_delta = '0;
      req_right_delta = '0;
      req_load_x = '0;
      req_load_y = '0;
      req_load_heading = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_update('0, '0);
      send_update(wheel_step'(-65536), wheel_step'(65536));
      send_update(wheel_step'(65536), wheel_step'(65536));
      send_update(STEP_MIN, STEP_MAX);
      send_update(STEP_MAX, STEP_MIN);
      send_update(STEP_MIN, STEP_MIN);
      send_update(STEP_MAX, STEP_MAX);
      send_load(POS_TOP, POS_BOTTOM, 0);
      send_update(STEP_MIN, STEP_MAX);
      send_load('0, POS_BOTTOM, -HALF_PI_FX);
      send_update(STEP_MIN, STEP_MAX);
      send_load(POS_BOTTOM, POS_TOP, PI_FX - 1);
      send_update(STEP_MIN, STEP_MAX);
      send_load('0, '0, 262143);
      send_load('0, '0, -262144);
      send_load('0, '0, PI_FX);
      send_load('0, '0, -PI_FX - 1);
      send_load('0, '0, -PI_FX);
      send_update(wheel_step'(100), wheel_step'(300));
      write_turn_scale('0);
      send_update(STEP_MIN, STEP_MIN);
      send_update(wheel_step'(1000), wheel_step'(-1000));
      write_turn_scale('1);
      send_update(wheel_step'(1), '0);
      send_update(STEP_MIN, STEP_MAX);
      send_update(STEP_MAX, STEP_MAX);

      run_phase(24'd131072, 325, 1'b0);
      run_phase(24'd0, 325, 1'b1);
      run_phase(24'hFFFFFF, 325, 1'b0);
      run_phase(turn_scale_word'($urandom_range(0, 24'hFFFFFF)), 325, 1'b1);
      run_phase(turn_scale_word'($urandom_range(16384, 400000)), 325, 1'b0);
      run_phase(24'd65536, 325, 1'b0);

      drain();
      repeat (25) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
